### rtl/bea_pkg.sv
// bea_pkg: shared types, field widths, codes and helpers for the block extent allocator
// no dependencies; compiled first
`timescale 1ns / 1ps

package bea_pkg;

    localparam int CMD_W   = 2;
    localparam int PIX_W   = 10;
    localparam int BLK_W   = 13;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 9;
    localparam int CFGI_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic [CFGI_W-1:0] CFG_BLOCK_W = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_BLOCK_H = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_PAGE_W  = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_PAGE_H  = 2'd3;

    localparam logic [BLK_W-1:0] STRIDE_RESET = 13'd65;

    typedef struct packed {
        logic [BLK_W-1:0] ext_begin;
        logic [CNT_W-1:0] size;
    } t_extent;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_INIT_STRIDE,
        S_INIT_ROWS,
        S_INIT_FILL,
        S_ALLOC_N,
        S_AL_RD,
        S_AL_EV,
        S_AL_POS,
        S_AL_MULX,
        S_AL_MULY,
        S_RL_RD,
        S_RL_EV,
        S_RL_DECIDE,
        S_RM_RD,
        S_RM_WR,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } t_state;

    // saturate an 8 bit sum to the 7 bit size field
    function automatic logic [CNT_W-1:0] bea_sat7(input logic [CNT_W:0] v);
        return v[CNT_W] ? {CNT_W{1'b1}} : v[CNT_W-1:0];
    endfunction

endpackage

### rtl/bea_cfg_if.sv
// bea_cfg_if: configuration write channel (register index and data)
// depends on bea_pkg
`timescale 1ns / 1ps

interface bea_cfg_if import bea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFGI_W-1:0] index;
    logic [PIX_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bea_in_if.sv
// bea_in_if: command channel into the allocator
// depends on bea_pkg
`timescale 1ns / 1ps

interface bea_in_if import bea_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
    logic [BLK_W-1:0] start_block;
    logic [CNT_W-1:0] block_count;

    modport source (output valid, command, width, height, start_block, block_count,
                    input ready);
    modport sink   (input valid, command, width, height, start_block, block_count,
                    output ready);
endinterface

### rtl/bea_out_if.sv
// bea_out_if: result channel out of the allocator
// depends on bea_pkg
`timescale 1ns / 1ps

interface bea_out_if import bea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  first_block;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [CNT_W-1:0]  blocks_taken;

    modport source (output valid, status, first_block, x_pos, y_pos, blocks_taken,
                    input ready);
    modport sink   (input valid, status, first_block, x_pos, y_pos, blocks_taken,
                    output ready);
endinterface

### rtl/bea_ram.sv
// bea_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bea_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/atlas_block_extent_allocator_top.sv
// atlas_block_extent_allocator_top: first fit extent allocator with coalescing release
// depends on bea_pkg, bea_cfg_if, bea_in_if, bea_out_if, bea_ram
//
//  channel  | dir | transfer carries
//  ---------+-----+-----------------------------------------------------------
//  i_cfg    | in  | index, data: block/page width/height register write
//  i_req    | in  | command, width, height, start_block, block_count
//  o_rsp    | out | status, first_block, x_pos, y_pos, blocks_taken
//
//  one command at a time; i_req.ready is high only while idle
//  init: two divisions, then one table entry written per row
//  allocate: a division, a scan of the extents, a tail shift when an extent
//  empties, another division, then the x and y multiply states
//  release: a scan of the extents plus a tail shift on insertion or removal
//  the steps use the shared restoring divider and the registered
//  read port of the extent ram; i_cfg is always ready; sync active low reset,
//  extent ram contents are not reset (only entries below the count are read)
`timescale 1ns / 1ps

module atlas_block_extent_allocator_top import bea_pkg::*; #(
    parameter int MAX_EXTENTS = 64,
    parameter int MAX_PAGE    = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bea_cfg_if.sink       i_cfg,
    bea_in_if.sink        i_req,
    bea_out_if.source     o_rsp
);
    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = $bits(t_extent);

    // configuration registers
    logic [PIX_W-1:0] r_cfg_bw, r_cfg_bh, r_cfg_pw, r_cfg_ph;

    // sequencer and shared divider state
    t_state           r_state, n_state, r_ret, n_ret;
    logic [3:0]       r_cnt, n_cnt;
    logic [10:0]      r_rem, n_rem;
    logic [10:0]      r_dvs, n_dvs;
    logic [BLK_W-1:0] r_quo, n_quo;

    // table bookkeeping
    logic [CW-1:0]    r_total, n_total;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_lim, n_lim;
    logic [7:0]       r_stride, n_stride;
    logic [BLK_W-1:0] r_beg, n_beg;
    logic [7:0]       r_n, n_n;
    logic [BLK_W-1:0] r_first, n_first;
    t_extent          r_prev, n_prev, r_cur, n_cur;
    logic             r_have_prev, n_have_prev, r_have_cur, n_have_cur;
    logic             r_is_alloc, n_is_alloc;

    // latched request
    logic [PIX_W-1:0] r_w, n_w;
    logic [BLK_W-1:0] r_sb, n_sb;
    logic [CNT_W-1:0] r_bc, n_bc;

    // result register
    logic [STAT_W-1:0] r_status, n_status;
    logic [BLK_W-1:0]  r_out_first, n_out_first;
    logic [POS_W-1:0]  r_xpos, n_xpos, r_ypos, n_ypos;
    logic [CNT_W-1:0]  r_taken, n_taken;

    // extent ram port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_extent          ram_wdata, ram_rdata;
    logic [EW-1:0]    ram_rbits;

    // effective block and page sizes
    logic [10:0]      bw_sum, bh_sum, bw_eff, bh_eff;
    logic [PIX_W-1:0] pw_eff, ph_eff;

    // divider step and multiplier
    logic [11:0]      rem_sh, rem_sub;
    logic             rem_ge;
    logic [POS_W-1:0] mul_a, mul_b;
    logic [2*POS_W-1:0] mul_p;

    // release merge terms
    logic [BLK_W:0]   prev_end, run_end;
    logic             join_prev, join_next;
    logic [CNT_W-1:0] size_p1, size_p2, size_nx;

    bea_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_extent'(ram_rbits);

    // block size rounds up to a multiple of eight, zero becomes eight
    assign bw_sum = 11'(r_cfg_bw) + 11'd7;
    assign bh_sum = 11'(r_cfg_bh) + 11'd7;
    assign bw_eff = (bw_sum[10:3] == 8'd0) ? 11'd8 : {bw_sum[10:3], 3'b000};
    assign bh_eff = (bh_sum[10:3] == 8'd0) ? 11'd8 : {bh_sum[10:3], 3'b000};
    // page size clamps to the largest page
    assign pw_eff = (int'(r_cfg_pw) > MAX_PAGE) ? PIX_W'(MAX_PAGE) : r_cfg_pw;
    assign ph_eff = (int'(r_cfg_ph) > MAX_PAGE) ? PIX_W'(MAX_PAGE) : r_cfg_ph;

    // one restoring divider step per cycle
    assign rem_sh  = {r_rem, r_quo[BLK_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // only the low nine bits of a pixel position survive, so 9x9 is enough
    assign mul_a = (r_state == S_AL_MULX) ? r_rem[POS_W-1:0] : r_quo[POS_W-1:0];
    assign mul_b = (r_state == S_AL_MULX) ? bw_eff[POS_W-1:0] : bh_eff[POS_W-1:0];
    assign mul_p = mul_a * mul_b;

    // neighbor tests for a release
    assign prev_end  = {1'b0, r_prev.ext_begin} + (BLK_W+1)'(r_prev.size);
    assign run_end   = {1'b0, r_sb} + (BLK_W+1)'(r_bc);
    assign join_prev = r_have_prev && (prev_end == {1'b0, r_sb});
    assign join_next = r_have_cur && ({1'b0, r_cur.ext_begin} == run_end);
    assign size_p1   = bea_sat7({1'b0, r_prev.size} + {1'b0, r_bc});
    assign size_p2   = join_next ? bea_sat7({1'b0, size_p1} + {1'b0, r_cur.size}) : size_p1;
    assign size_nx   = bea_sat7({1'b0, r_cur.size} + {1'b0, r_bc});

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid        = (r_state == S_DONE);
    assign o_rsp.status       = r_status;
    assign o_rsp.first_block  = r_out_first;
    assign o_rsp.x_pos        = r_xpos;
    assign o_rsp.y_pos        = r_ypos;
    assign o_rsp.blocks_taken = r_taken;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bw <= 10'd8;
            r_cfg_bh <= 10'd8;
            r_cfg_pw <= 10'd512;
            r_cfg_ph <= 10'd512;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BLOCK_W: r_cfg_bw <= i_cfg.data;
                CFG_BLOCK_H: r_cfg_bh <= i_cfg.data;
                CFG_PAGE_W:  r_cfg_pw <= i_cfg.data;
                CFG_PAGE_H:  r_cfg_ph <= i_cfg.data;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_stride    <= STRIDE_RESET[7:0];
            r_have_prev <= 1'b0;
            r_have_cur  <= 1'b0;
            r_is_alloc  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_stride    <= n_stride;
            r_have_prev <= n_have_prev;
            r_have_cur  <= n_have_cur;
            r_is_alloc  <= n_is_alloc;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_cnt       <= n_cnt;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_quo       <= n_quo;
        r_idx       <= n_idx;
        r_j         <= n_j;
        r_lim       <= n_lim;
        r_beg       <= n_beg;
        r_n         <= n_n;
        r_first     <= n_first;
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_w         <= n_w;
        r_sb        <= n_sb;
        r_bc        <= n_bc;
        r_status    <= n_status;
        r_out_first <= n_out_first;
        r_xpos      <= n_xpos;
        r_ypos      <= n_ypos;
        r_taken     <= n_taken;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_total     = r_total;
        n_idx       = r_idx;
        n_j         = r_j;
        n_lim       = r_lim;
        n_stride    = r_stride;
        n_beg       = r_beg;
        n_n         = r_n;
        n_first     = r_first;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_have_prev = r_have_prev;
        n_have_cur  = r_have_cur;
        n_is_alloc  = r_is_alloc;
        n_w         = r_w;
        n_sb        = r_sb;
        n_bc        = r_bc;
        n_status    = r_status;
        n_out_first = r_out_first;
        n_xpos      = r_xpos;
        n_ypos      = r_ypos;
        n_taken     = r_taken;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = '0;
        ram_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_w         = i_req.width;
                    n_sb        = i_req.start_block;
                    n_bc        = i_req.block_count;
                    n_status    = ST_OK;
                    n_out_first = '0;
                    n_xpos      = '0;
                    n_ypos      = '0;
                    n_taken     = '0;
                    n_idx       = '0;
                    n_have_prev = 1'b0;
                    n_have_cur  = 1'b0;
                    n_cnt       = '0;
                    n_rem       = '0;
                    unique case (i_req.command)
                        CMD_INIT: begin
                            n_quo   = BLK_W'(pw_eff);
                            n_dvs   = bw_eff;
                            n_ret   = S_INIT_STRIDE;
                            n_state = S_DIV;
                        end
                        CMD_ALLOC: begin
                            n_is_alloc = 1'b1;
                            if (11'(i_req.height) > bh_eff || i_req.width > pw_eff) begin
                                n_status = ST_TOO_LARGE;
                                n_state  = S_DONE;
                            end else begin
                                n_quo   = BLK_W'(11'(i_req.width) + bw_eff - 11'd1);
                                n_dvs   = bw_eff;
                                n_ret   = S_ALLOC_N;
                                n_state = S_DIV;
                            end
                        end
                        CMD_RELEASE: begin
                            n_is_alloc = 1'b0;
                            // an empty run is a no-op
                            n_state = (i_req.block_count == '0) ? S_DONE : S_RL_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DIV: begin
                n_rem = rem_ge ? rem_sub[10:0] : rem_sh[10:0];
                n_quo = {r_quo[BLK_W-2:0], rem_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(BLK_W - 1)) begin
                    n_state = r_ret;
                end
            end

            S_INIT_STRIDE: begin
                n_stride = r_quo[7:0] + 8'd1;
                n_quo    = BLK_W'(ph_eff);
                n_dvs    = bh_eff;
                n_rem    = '0;
                n_cnt    = '0;
                n_ret    = S_INIT_ROWS;
                n_state  = S_DIV;
            end

            S_INIT_ROWS: begin
                n_total = '0;
                n_idx   = '0;
                n_beg   = '0;
                if (r_stride == 8'd1) begin
                    // page narrower than a block: no row holds a block
                    n_state = S_DONE;
                end else if (9'(r_quo[7:0]) > 9'(MAX_EXTENTS)) begin
                    n_lim    = CW'(MAX_EXTENTS);
                    n_status = ST_FULL;
                    n_state  = S_INIT_FILL;
                end else begin
                    n_lim   = CW'(r_quo[7:0]);
                    n_state = S_INIT_FILL;
                end
            end

            S_INIT_FILL: begin
                if (r_idx == r_lim) begin
                    n_total = r_lim;
                    n_state = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = '{ext_begin: r_beg, size: CNT_W'(r_stride - 8'd1)};
                    n_beg     = r_beg + BLK_W'(r_stride);
                    n_idx     = r_idx + CW'(1);
                end
            end

            S_ALLOC_N: begin
                // zero width still takes one block
                n_n     = (r_w == '0) ? 8'd1 : r_quo[7:0];
                n_state = S_AL_RD;
            end

            S_AL_RD: begin
                if (r_idx < r_total) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = S_AL_EV;
                end else begin
                    n_status = ST_NO_FIT;
                    n_state  = S_DONE;
                end
            end

            S_AL_EV: begin
                if (8'(ram_rdata.size) >= r_n) begin
                    n_first = ram_rdata.ext_begin;
                    if (8'(ram_rdata.size) == r_n) begin
                        n_j     = r_idx;
                        n_state = S_RM_RD;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx[AW-1:0];
                        ram_wdata = '{ext_begin: ram_rdata.ext_begin + BLK_W'(r_n),
                                      size: ram_rdata.size - r_n[CNT_W-1:0]};
                        n_state   = S_AL_POS;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_AL_RD;
                end
            end

            S_AL_POS: begin
                n_quo   = r_first;
                n_dvs   = 11'(r_stride);
                n_rem   = '0;
                n_cnt   = '0;
                n_ret   = S_AL_MULX;
                n_state = S_DIV;
            end

            S_AL_MULX: begin
                n_xpos  = mul_p[POS_W-1:0];
                n_state = S_AL_MULY;
            end

            S_AL_MULY: begin
                n_ypos      = mul_p[POS_W-1:0];
                n_status    = ST_OK;
                n_out_first = r_first;
                n_taken     = r_n[CNT_W-1:0];
                n_state     = S_DONE;
            end

            S_RL_RD: begin
                if (r_idx < r_total) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = S_RL_EV;
                end else begin
                    n_have_cur = 1'b0;
                    n_state    = S_RL_DECIDE;
                end
            end

            S_RL_EV: begin
                if (ram_rdata.ext_begin < r_sb) begin
                    n_prev      = ram_rdata;
                    n_have_prev = 1'b1;
                    n_idx       = r_idx + CW'(1);
                    n_state     = S_RL_RD;
                end else begin
                    n_cur      = ram_rdata;
                    n_have_cur = 1'b1;
                    n_state    = S_RL_DECIDE;
                end
            end

            S_RL_DECIDE: begin
                if (join_prev) begin
                    // grow the extent in front, then drop the one behind if it touches too
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_idx - CW'(1));
                    ram_wdata = '{ext_begin: r_prev.ext_begin, size: size_p2};
                    if (join_next) begin
                        n_j     = r_idx;
                        n_state = S_RM_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (join_next) begin
                    // extent behind moves back and grows by the run
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = '{ext_begin: r_sb, size: size_nx};
                    n_state   = S_DONE;
                end else if (r_total >= CW'(MAX_EXTENTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_j     = r_total;
                    n_state = S_INS_RD;
                end
            end

            // remove entry r_j: move the tail down one entry at a time, a read then a write
            S_RM_RD: begin
                if ((r_j + CW'(1)) < r_total) begin
                    ram_raddr = AW'(r_j + CW'(1));
                    n_state   = S_RM_WR;
                end else begin
                    n_total = r_total - CW'(1);
                    n_state = r_is_alloc ? S_AL_POS : S_DONE;
                end
            end

            S_RM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = r_j + CW'(1);
                n_state   = S_RM_RD;
            end

            // insert at r_idx: move the tail up from the end, then write the run
            S_INS_RD: begin
                if (r_j > r_idx) begin
                    ram_raddr = AW'(r_j - CW'(1));
                    n_state   = S_INS_WR;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = '{ext_begin: r_sb, size: r_bc};
                    n_total   = r_total + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = r_j - CW'(1);
                n_state   = S_INS_RD;
            end

            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // never ready for a command while a result waits
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("command ready while result pending");

    // a command transfer leaves the idle state at once
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("still ready after command transfer");

    // only a granted allocate carries a block position
    a_zero_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.first_block == '0 && o_rsp.blocks_taken == '0))
        else $error("failed command carries a grant");

    // the extent count stays within the table
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_total <= CW'(MAX_EXTENTS)))
        else $error("extent count beyond table");

endmodule

### tb/tb.sv
// tb: self-checking testbench for atlas_block_extent_allocator_top
// depends on bea_pkg, bea_cfg_if, bea_in_if, bea_out_if and the allocator rtl
`timescale 1ns / 1ps

module tb;
    import bea_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int PAGE_CAP    = 512;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 75;

    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
        logic [BLK_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  first_block;
        logic [POS_W-1:0]  x_pos;
        logic [POS_W-1:0]  y_pos;
        logic [CNT_W-1:0]  blocks_taken;
    } t_rsp;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } t_run;

    logic i_clk;
    logic i_rst_n;

    bea_cfg_if cfg_if ();
    bea_in_if  req_if ();
    bea_out_if rsp_if ();

    atlas_block_extent_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // free extent table mirror, kept in sorted order like the block's
    int unsigned ext_first [TABLE_DEPTH];
    int unsigned ext_len   [TABLE_DEPTH];
    int unsigned ext_count;
    int unsigned stride;
    int unsigned reg_bw, reg_bh, reg_pw, reg_ph;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    t_run granted_runs[$];

    t_req next_req;
    bit   req_fire, rsp_fire;
    bit   req_idle, rsp_idle;
    int   req_gap, rsp_gap;
    int   hold_cycles;
    int   mismatches;
    int   quiet_cycles;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // block dimensions round up to a multiple of eight, minimum eight
    function automatic int unsigned eff_block(int unsigned v);
        int unsigned r;
        r = (v + 7) & ~32'd7;
        return (r < 8) ? 8 : r;
    endfunction

    function automatic int unsigned eff_page(int unsigned v);
        return (v > PAGE_CAP) ? PAGE_CAP : v;
    endfunction

    // mirror of the allocator: updates the extent table and returns the response
    function automatic t_rsp allocator_response(t_req r);
        t_rsp o;
        int unsigned bw, bh, pw, ph, rows, n, i, k, s, len, first;
        bit jp, jn;
        o = '0;
        bw = eff_block(reg_bw);
        bh = eff_block(reg_bh);
        pw = eff_page(reg_pw);
        ph = eff_page(reg_ph);
        case (r.command)
            CMD_INIT: begin
                rows = ph / bh;
                stride = pw / bw + 1;
                ext_count = 0;
                for (int y = 0; y < rows; y++) begin
                    if (stride - 1 == 0)
                        continue;
                    if (ext_count >= TABLE_DEPTH) begin
                        o.status = ST_FULL;
                        break;
                    end
                    ext_first[ext_count] = (y * stride) & 32'h1FFF;
                    ext_len[ext_count] = (stride - 1 > 127) ? 127 : stride - 1;
                    ext_count++;
                end
            end
            CMD_ALLOC: begin
                if (r.height > bh || r.width > pw) begin
                    o.status = ST_TOO_LARGE;
                end else begin
                    n = (r.width == 0) ? 1 : (r.width + bw - 1) / bw;
                    o.status = ST_NO_FIT;
                    for (i = 0; i < ext_count; i++) begin
                        if (ext_len[i] >= n) begin
                            first = ext_first[i];
                            ext_first[i] = (ext_first[i] + n) & 32'h1FFF;
                            ext_len[i] -= n;
                            // an emptied extent leaves the table
                            if (ext_len[i] == 0) begin
                                for (k = i; k + 1 < ext_count; k++) begin
                                    ext_first[k] = ext_first[k+1];
                                    ext_len[k] = ext_len[k+1];
                                end
                                ext_count--;
                            end
                            o.status = ST_OK;
                            o.first_block = BLK_W'(first);
                            o.x_pos = POS_W'(((first % stride) * bw) & 32'h1FF);
                            o.y_pos = POS_W'(((first / stride) * bh) & 32'h1FF);
                            o.blocks_taken = CNT_W'(n);
                            break;
                        end
                    end
                end
            end
            CMD_RELEASE: begin
                s = 32'(r.start_block);
                len = 32'(r.block_count);
                if (len != 0) begin
                    i = 0;
                    while (i < ext_count && ext_first[i] < s)
                        i++;
                    jp = i > 0 && ext_first[i-1] + ext_len[i-1] == s;
                    jn = i < ext_count && ext_first[i] == s + len;
                    if (jp) begin
                        ext_len[i-1] = (ext_len[i-1] + len > 127) ? 127 : ext_len[i-1] + len;
                        if (jn) begin
                            ext_len[i-1] = (ext_len[i-1] + ext_len[i] > 127) ? 127
                                         : ext_len[i-1] + ext_len[i];
                            for (k = i; k + 1 < ext_count; k++) begin
                                ext_first[k] = ext_first[k+1];
                                ext_len[k] = ext_len[k+1];
                            end
                            ext_count--;
                        end
                    end else if (jn) begin
                        // front merge moves the extent back and grows it
                        ext_first[i] = s;
                        ext_len[i] = (ext_len[i] + len > 127) ? 127 : ext_len[i] + len;
                    end else if (ext_count >= TABLE_DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        for (k = ext_count; k > i; k--) begin
                            ext_first[k] = ext_first[k-1];
                            ext_len[k] = ext_len[k-1];
                        end
                        ext_first[i] = s;
                        ext_len[i] = len;
                        ext_count++;
                    end
                end
            end
            default: ;
        endcase
        if (r.command == CMD_ALLOC && o.status == ST_OK)
            granted_runs.push_back('{first: 32'(o.first_block),
                                     count: 32'(o.blocks_taken)});
        return o;
    endfunction

    // request driver: fed from pending_reqs, random gap after each transfer when req_idle is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                req_if.command     <= next_req.command;
                req_if.width       <= next_req.width;
                req_if.height      <= next_req.height;
                req_if.start_block <= next_req.start_block;
                req_if.block_count <= next_req.block_count;
                req_if.valid       <= 1'b1;
                req_gap = req_idle ? $urandom_range(0, 16) : 0;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response ready: random gaps when rsp_idle is set, plus the long hold-off when requested
    always @(negedge i_clk) begin
        if (rsp_fire)
            rsp_gap = rsp_idle ? $urandom_range(0, 16) : 0;
        if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // monitor: predict on request transfer, check on response transfer
    always @(posedge i_clk) begin
        t_rsp got, want;
        req_fire = i_rst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1;
        rsp_fire = i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1;
        if (req_fire)
            expected_rsps.push_back(allocator_response({req_if.command, req_if.width,
                req_if.height, req_if.start_block, req_if.block_count}));
        if (rsp_fire) begin
            got = {rsp_if.status, rsp_if.first_block, rsp_if.x_pos, rsp_if.y_pos,
                   rsp_if.blocks_taken};
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: response with nothing expected: st=%0d blk=%0d",
                             got.status, got.first_block);
            end else begin
                want = expected_rsps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"tb: mismatch exp st=%0d blk=%0d x=%0d y=%0d n=%0d",
                                  " | got st=%0d blk=%0d x=%0d y=%0d n=%0d"},
                                 want.status, want.first_block, want.x_pos, want.y_pos,
                                 want.blocks_taken, got.status, got.first_block, got.x_pos,
                                 got.y_pos, got.blocks_taken);
                end
            end
        end
        // watchdog on cycles with no transfer anywhere
        if (req_fire || rsp_fire || (cfg_if.valid && cfg_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic queue_req(logic [CMD_W-1:0] cmd, int unsigned w, int unsigned h,
                             int unsigned sb, int unsigned bc);
        t_req r;
        while (pending_reqs.size() >= 2)
            @(posedge i_clk);
        r.command = cmd;
        r.width = PIX_W'(w);
        r.height = PIX_W'(h);
        r.start_block = BLK_W'(sb);
        r.block_count = CNT_W'(bc);
        pending_reqs.push_back(r);
    endtask

    // wait until the block is idle and every response has been checked
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= PIX_W'(value);
        cfg_if.valid <= 1'b1;
        do
            @(posedge i_clk);
        while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_BLOCK_W: reg_bw = value & 32'h3FF;
            CFG_BLOCK_H: reg_bh = value & 32'h3FF;
            CFG_PAGE_W:  reg_pw = value & 32'h3FF;
            default:     reg_ph = value & 32'h3FF;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // one random item: mostly well-formed allocs and releases, some noise
    task automatic random_item();
        int unsigned pick, pw, bh, k;
        t_run run;
        pick = $urandom_range(0, 99);
        pw = eff_page(reg_pw);
        bh = eff_block(reg_bh);
        if (pick < 3) begin
            queue_req(CMD_INIT, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 53) begin
            if ($urandom_range(0, 9) == 0)
                queue_req(CMD_ALLOC, $urandom, $urandom, $urandom, $urandom);
            else
                queue_req(CMD_ALLOC, $urandom_range(0, pw), $urandom_range(0, bh),
                          $urandom, $urandom);
        end else if (pick < 88 && granted_runs.size() > 0) begin
            k = $urandom_range(0, granted_runs.size() - 1);
            run = granted_runs[k];
            granted_runs.delete(k);
            queue_req(CMD_RELEASE, $urandom, $urandom, run.first, run.count);
        end else if (pick < 94) begin
            queue_req(CMD_RELEASE, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 97) begin
            queue_req(CMD_RELEASE, $urandom, $urandom, $urandom, 0);
        end else begin
            queue_req(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int unsigned bw_set [6] = '{8, 512, 8, 24, 0, 40};
        int unsigned bh_set [6] = '{8, 512, 8, 16, 1023, 8};
        int unsigned pw_set [6] = '{512, 512, 8, 200, 1023, 1000};
        int unsigned ph_set [6] = '{512, 512, 8, 300, 0, 700};
        int unsigned bw, bh, pw, ph;

        reg_bw = 8;
        reg_bh = 8;
        reg_pw = 512;
        reg_ph = 512;
        ext_count = 0;
        stride = 65;
        mismatches = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        req_gap = 0;
        rsp_gap = 0;
        req_idle = 0;
        rsp_idle = 0;
        req_fire = 0;
        rsp_fire = 0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_BLOCK_W;
        cfg_if.data = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_INIT;
        req_if.width = '0;
        req_if.height = '0;
        req_if.start_block = '0;
        req_if.block_count = '0;
        rsp_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, 512x512 page of 8x8 blocks, stride 65
        queue_req(CMD_ALLOC, 8, 8, 0, 0);              // empty table, no fit
        queue_req(CMD_RELEASE, 0, 0, 5, 0);            // zero length is ignored
        queue_req(CMD_UNUSED, 1023, 1023, 8191, 127);  // unused command
        queue_req(CMD_INIT, 0, 0, 0, 0);               // 64 rows fill the table
        queue_req(CMD_RELEASE, 0, 0, 8191, 127);       // new extent with full table
        queue_req(CMD_RELEASE, 0, 0, 64, 64);          // back merge saturating at 127
        queue_req(CMD_ALLOC, 0, 1, 0, 0);              // zero width takes one block
        queue_req(CMD_RELEASE, 0, 0, 0, 1);            // front merge
        queue_req(CMD_ALLOC, 8, 8, 0, 0);
        queue_req(CMD_ALLOC, 8, 8, 0, 0);
        queue_req(CMD_RELEASE, 0, 0, 0, 1);            // standalone extent
        queue_req(CMD_RELEASE, 0, 0, 1, 1);            // merge on both sides
        queue_req(CMD_ALLOC, 512, 8, 0, 0);            // whole row
        queue_req(CMD_ALLOC, 513, 1, 0, 0);            // wider than page
        queue_req(CMD_ALLOC, 1, 9, 0, 0);              // taller than block
        queue_req(CMD_ALLOC, 1023, 1023, 0, 0);
        queue_req(CMD_ALLOC, 1, 0, 0, 0);
        queue_req(CMD_ALLOC, 511, 8, 0, 0);
        queue_req(CMD_RELEASE, 1023, 1023, 4160, 64);
        queue_req(CMD_INIT, 0, 0, 0, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 6) begin
                bw = bw_set[p];
                bh = bh_set[p];
                pw = pw_set[p];
                ph = ph_set[p];
            end else begin
                bw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : 8 * $urandom_range(1, 64);
                bh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : 8 * $urandom_range(1, 64);
                pw = $urandom_range(8, 1023);
                ph = $urandom_range(8, 512);
                // small blocks keep the even phases busy
                if (p % 2 == 0) begin
                    bw = 8 * $urandom_range(1, 4);
                    bh = 8 * $urandom_range(1, 8);
                end
            end
            write_reg(CFG_BLOCK_W, bw);
            write_reg(CFG_BLOCK_H, bh);
            write_reg(CFG_PAGE_W, pw);
            write_reg(CFG_PAGE_H, ph);
            req_idle = $urandom_range(0, 3) != 0;
            rsp_idle = $urandom_range(0, 3) != 0;
            granted_runs.delete();
            queue_req(CMD_INIT, 0, 0, 0, 0);
            if (p == 3)
                hold_cycles = 400;                     // back up the response side
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // block size changed after init, table kept
                if (p >= 6 && n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) begin
                    drain();
                    write_reg(CFG_BLOCK_W, 8 * $urandom_range(1, 8));
                    write_reg(CFG_BLOCK_H, 8 * $urandom_range(1, 64));
                end
                random_item();
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/bea_pkg.sv
rtl/bea_cfg_if.sv
rtl/bea_in_if.sv
rtl/bea_out_if.sv
rtl/bea_ram.sv
rtl/atlas_block_extent_allocator_top.sv
tb/tb.sv
